@@ rtl/core/mlfe_pkg.sv @@
// Shared types, constants and helpers for the motor link frame engine.
package mlfe_pkg;

  // Motors handled by the link; data slots of higher motors carry zero.
  localparam int MOTOR_COUNT = 4;

  // Frame layout.
  localparam logic [7:0] FRAME_HEAD = 8'hA5;
  localparam logic [3:0] FRAME_SUM_SPAN = 4'd10;
  localparam logic [3:0] FRAME_LAST_IDX = 4'd10;
  localparam int DATA_BYTES = 8;

  // Request modes.
  localparam logic [1:0] MODE_RX = 2'd0;
  localparam logic [1:0] MODE_DUTY = 2'd1;
  localparam logic [1:0] MODE_SPEED_REQ = 2'd2;
  localparam logic [1:0] MODE_TEST = 2'd3;

  // Function codes of transmitted frames.
  localparam logic [7:0] FUNC_DUTY = 8'h01;
  localparam logic [7:0] FUNC_SPEED_REQ = 8'h02;
  localparam logic [7:0] FUNC_TEST = 8'h03;

  // Result kinds.
  localparam logic KIND_TX = 1'b0;
  localparam logic KIND_SPEED = 1'b1;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         rx_byte;
    logic signed [15:0] duty_one;
    logic signed [15:0] duty_two;
    logic signed [15:0] duty_three;
    logic signed [15:0] duty_four;
  } cmd_item_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         tx_byte;
    logic               last_byte;
    logic signed [15:0] speed_one;
    logic signed [15:0] speed_two;
    logic signed [15:0] speed_three;
    logic signed [15:0] speed_four;
  } res_item_t;

  // Work handed to the back part: a frame to send or a speed report.
  // data[i] is frame byte 2+i.
  typedef struct packed {
    logic                       kind;
    logic [7:0]                 code;
    logic [DATA_BYTES-1:0][7:0] data;
    logic [7:0]                 sum;
  } qentry_t;

  // Function code that belongs to a send mode.
  function automatic logic [7:0] func_code(input logic [1:0] mode);
    logic [7:0] code;
    case (mode)
      MODE_DUTY:      code = FUNC_DUTY;
      MODE_SPEED_REQ: code = FUNC_SPEED_REQ;
      MODE_TEST:      code = FUNC_TEST;
      default:        code = FUNC_TEST;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/core/mlfe_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface mlfe_cmd_if;
  import mlfe_pkg::*;
  logic      valid;
  logic      ready;
  cmd_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlfe_res_if;
  import mlfe_pkg::*;
  logic      valid;
  logic      ready;
  res_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/motor_link_frame_engine_top.sv @@
// Top level of the motor link frame engine.
// The engine links a host to a four-motor driver over 11-byte frames.
// Requests arrive on the cmd channel: mode 0 carries one received byte,
// modes 1 to 3 ask for a duty, speed request or test frame to be sent.
// Results leave on the res channel: kind 0 is one byte to transmit, with
// last_byte set on the checksum byte; kind 1 carries four speeds from a
// received frame whose checksum matched. Bad frames give no result.
// The front part takes one request per cycle while its four-entry queue
// has room, so received bytes stream at one per cycle. The back part turns
// each queued send into eleven result transactions, one per cycle while the
// receiver takes them, and a speed report into one. An accepted request is
// written into the queue first, and its first result is then loaded into the
// output register. When the receiver stalls, the output register holds, the
// queue fills and cmd.ready drops once four entries wait.
// Reset empties the queue and the output register and abandons any frame
// being received.
module motor_link_frame_engine_top (
  input  logic      clk,
  input  logic      rst,
  mlfe_cmd_if.sink  cmd,
  mlfe_res_if.source res
);
  import mlfe_pkg::*;

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_nonempty;
  qentry_t q_entry;
  qentry_t q_head;

  mlfe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  mlfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .full       (q_full),
    .nonempty   (q_nonempty),
    .head       (q_head)
  );

  mlfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .res        (res)
  );

`ifndef ASSERT_OFF
  // The front part never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("queue written while full");

  // Only transmit bytes may carry the end-of-frame flag.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.data.last_byte) |-> (res.data.kind == KIND_TX))
    else $error("end-of-frame flag on a speed result");

  // Retiring a send frame presents its checksum byte next.
  a_last_on_pop: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.kind == KIND_TX) |=> (res.valid && res.data.last_byte))
    else $error("send frame retired without its final byte");
`endif

endmodule

@@ rtl/core/mlfe_queue.sv @@
// Short first-in first-out queue between the front and back parts.
module mlfe_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mlfe_pkg::qentry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              nonempty,
  output mlfe_pkg::qentry_t head
);
  import mlfe_pkg::*;

  qentry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  // Pointer and occupancy bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ rtl/core/mlfe_front.sv @@
// Front part: accepts requests, tracks received frames, queues work.
module mlfe_front (
  input  logic              clk,
  input  logic              rst,
  mlfe_cmd_if.sink          cmd,
  input  logic              q_full,
  output logic              q_push,
  output mlfe_pkg::qentry_t q_entry
);
  import mlfe_pkg::*;

  logic [3:0]  rx_count;
  logic [3:0]  rx_count_next;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_sum_next;
  logic [7:0]  rx_data [DATA_BYTES];
  logic        rx_store;
  logic        accept;
  logic [7:0]  rx_b;
  logic [DATA_BYTES-1:0][7:0] duty_bytes;
  logic [DATA_BYTES-1:0][7:0] speed_bytes;
  logic [7:0]  tx_sum;
  logic [7:0]  tx_code;

  assign cmd.ready = !q_full;
  assign accept    = cmd.valid && cmd.ready;
  assign rx_b      = cmd.data.rx_byte;
  assign tx_code   = func_code(cmd.data.mode);

  // Duty bytes for a send frame, big-endian, unused motors zero.
  always_comb begin
    duty_bytes = '0;
    if (cmd.data.mode == MODE_DUTY) begin
      duty_bytes[0] = cmd.data.duty_one[15:8];
      duty_bytes[1] = cmd.data.duty_one[7:0];
      duty_bytes[2] = cmd.data.duty_two[15:8];
      duty_bytes[3] = cmd.data.duty_two[7:0];
      duty_bytes[4] = cmd.data.duty_three[15:8];
      duty_bytes[5] = cmd.data.duty_three[7:0];
      duty_bytes[6] = cmd.data.duty_four[15:8];
      duty_bytes[7] = cmd.data.duty_four[7:0];
      for (int m = MOTOR_COUNT; m < 4; m++) begin
        duty_bytes[2*m]   = '0;
        duty_bytes[2*m+1] = '0;
      end
    end
  end

  // Checksum of an outgoing frame: header, code and eight data bytes.
  always_comb begin
    tx_sum = FRAME_HEAD + tx_code;
    for (int i = 0; i < DATA_BYTES; i++) begin
      tx_sum = tx_sum + duty_bytes[i];
    end
  end

  // Speeds from a stored frame; unused motors read as zero.
  always_comb begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      speed_bytes[i] = (i < 2 * MOTOR_COUNT) ? rx_data[i] : 8'h00;
    end
  end

  // Receive tracking and queue requests.
  always_comb begin
    rx_count_next = rx_count;
    rx_sum_next   = rx_sum;
    rx_store      = 1'b0;
    q_push        = 1'b0;
    q_entry.kind  = KIND_TX;
    q_entry.code  = tx_code;
    q_entry.data  = duty_bytes;
    q_entry.sum   = tx_sum;
    if (accept) begin
      if (cmd.data.mode == MODE_RX) begin
        if (rx_count == '0 && rx_b != FRAME_HEAD) begin
          rx_count_next = rx_count;
        end else if (rx_count < FRAME_SUM_SPAN) begin
          rx_store      = (rx_count >= 4'd2);
          rx_sum_next   = rx_sum + rx_b;
          rx_count_next = rx_count + 1'b1;
        end else begin
          // Checksum byte: report on a match, drop otherwise.
          rx_count_next = '0;
          rx_sum_next   = '0;
          q_push        = (rx_b == rx_sum);
          q_entry.kind  = KIND_SPEED;
          q_entry.code  = '0;
          q_entry.data  = speed_bytes;
          q_entry.sum   = '0;
        end
      end else begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count <= '0;
      rx_sum   <= '0;
    end else begin
      rx_count <= rx_count_next;
      rx_sum   <= rx_sum_next;
    end
  end

  // Data byte store; written only, so no reset is needed.
  always_ff @(posedge clk) begin
    if (rx_store) begin
      rx_data[3'(rx_count - 4'd2)] <= rx_b;
    end
  end

endmodule

@@ rtl/core/mlfe_back.sv @@
// Back part: drains queued work into the registered result channel.
module mlfe_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_nonempty,
  input  mlfe_pkg::qentry_t q_head,
  output logic              q_pop,
  mlfe_res_if.source        res
);
  import mlfe_pkg::*;

  logic [3:0] byte_idx;
  logic       load;
  logic [7:0] cur_byte;
  res_item_t  item;

  assign load  = q_nonempty && (!res.valid || res.ready);
  assign q_pop = load && (q_head.kind == KIND_SPEED || byte_idx == FRAME_LAST_IDX);

  // Frame byte at the current position.
  always_comb begin
    case (byte_idx)
      4'd0:    cur_byte = FRAME_HEAD;
      4'd1:    cur_byte = q_head.code;
      4'd10:   cur_byte = q_head.sum;
      default: cur_byte = q_head.data[3'(byte_idx - 4'd2)];
    endcase
  end

  // Result built from the queue head.
  always_comb begin
    item = '0;
    item.kind = q_head.kind;
    if (q_head.kind == KIND_SPEED) begin
      item.speed_one   = {q_head.data[0], q_head.data[1]};
      item.speed_two   = {q_head.data[2], q_head.data[3]};
      item.speed_three = {q_head.data[4], q_head.data[5]};
      item.speed_four  = {q_head.data[6], q_head.data[7]};
    end else begin
      item.tx_byte   = cur_byte;
      item.last_byte = (byte_idx == FRAME_LAST_IDX);
    end
  end

  // Output register and byte position.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      byte_idx  <= '0;
    end else if (load) begin
      res.valid <= 1'b1;
      if (q_pop) begin
        byte_idx <= '0;
      end else begin
        byte_idx <= byte_idx + 1'b1;
      end
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.data <= item;
    end
  end

endmodule

@@ bench/tb_motor_link_frame_engine_top.sv @@
// Self-checking testbench for the motor link frame engine: predicted frames and speed reports.
module tb_motor_link_frame_engine_top;
  import mlfe_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RESET_CYCLES = 6;

  logic clk;
  logic rst;

  mlfe_cmd_if cmd_ch ();
  mlfe_res_if res_ch ();

  motor_link_frame_engine_top uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // Results still owed by the engine, oldest first.
  res_item_t pending_results[$];

  // Predicted receive state: bytes held of the current frame, the bytes and their sum.
  logic [3:0] rx_held;
  logic [7:0] rx_bytes[10];
  logic [7:0] rx_sum;

  int src_idle_pct;
  int sink_stall_pct;
  int hold_cycles;
  int err_count = 0;
  int cycle_count = 0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung engine ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: a long hold-off when one is requested, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_ch.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // One line per mismatch; printing is capped but every one is counted.
  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // Works out the results that one accepted request must cause.
  function automatic void predict_link_item(input cmd_item_t item);
    logic [7:0] code;
    logic [7:0] frame[11];
    logic [7:0] sum;
    logic [15:0] word[4];
    res_item_t r;
    if (item.mode == MODE_RX) begin
      // Outside a frame only the header byte matters.
      if (rx_held == 4'd0 && item.rx_byte != FRAME_HEAD) return;
      if (rx_held < FRAME_SUM_SPAN) begin
        rx_bytes[rx_held] = item.rx_byte;
        rx_sum = rx_sum + item.rx_byte;
        rx_held = rx_held + 4'd1;
        return;
      end
      // The eleventh byte is the checksum; a bad frame vanishes without a result.
      if (item.rx_byte == rx_sum) begin
        for (int m = 0; m < 4; m++)
          word[m] = (m < MOTOR_COUNT) ? {rx_bytes[2 + 2 * m], rx_bytes[3 + 2 * m]} : 16'h0000;
        r = '0;
        r.kind = KIND_SPEED;
        r.speed_one = word[0];
        r.speed_two = word[1];
        r.speed_three = word[2];
        r.speed_four = word[3];
        pending_results.push_back(r);
      end
      rx_held = 4'd0;
      rx_sum = 8'h00;
      return;
    end
    // Send modes build a whole frame and leave the receive state alone.
    case (item.mode)
      MODE_DUTY:      code = FUNC_DUTY;
      MODE_SPEED_REQ: code = FUNC_SPEED_REQ;
      default:        code = FUNC_TEST;
    endcase
    word[0] = item.duty_one;
    word[1] = item.duty_two;
    word[2] = item.duty_three;
    word[3] = item.duty_four;
    for (int m = 0; m < 4; m++)
      if (item.mode != MODE_DUTY || m >= MOTOR_COUNT) word[m] = 16'h0000;
    frame[0] = FRAME_HEAD;
    frame[1] = code;
    for (int m = 0; m < 4; m++) begin
      frame[2 + 2 * m] = word[m][15:8];
      frame[3 + 2 * m] = word[m][7:0];
    end
    sum = 8'h00;
    for (int i = 0; i < 10; i++) sum = sum + frame[i];
    frame[10] = sum;
    for (int i = 0; i < 11; i++) begin
      r = '0;
      r.kind = KIND_TX;
      r.tx_byte = frame[i];
      r.last_byte = (i == FRAME_LAST_IDX);
      pending_results.push_back(r);
    end
  endfunction

  // Compares one result transaction with the oldest expectation, field by field.
  task automatic check_result(input res_item_t got);
    res_item_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected (kind %0b byte %02h)",
                                got.kind, got.tx_byte));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0b, expected %0b", got.kind, want.kind));
    if (got.tx_byte !== want.tx_byte)
      report_mismatch($sformatf("tx_byte %02h, expected %02h", got.tx_byte, want.tx_byte));
    if (got.last_byte !== want.last_byte)
      report_mismatch($sformatf("last_byte %0b, expected %0b", got.last_byte, want.last_byte));
    if (got.speed_one !== want.speed_one)
      report_mismatch($sformatf("speed_one %04h, expected %04h", got.speed_one, want.speed_one));
    if (got.speed_two !== want.speed_two)
      report_mismatch($sformatf("speed_two %04h, expected %04h", got.speed_two, want.speed_two));
    if (got.speed_three !== want.speed_three)
      report_mismatch($sformatf("speed_three %04h, expected %04h",
                                got.speed_three, want.speed_three));
    if (got.speed_four !== want.speed_four)
      report_mismatch($sformatf("speed_four %04h, expected %04h",
                                got.speed_four, want.speed_four));
  endtask

  // Every accepted result transaction is checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) check_result(res_ch.data);
  end

  // Offers one request, with random idle cycles first, and predicts it once accepted.
  task automatic send_request(input cmd_item_t item);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= item;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    predict_link_item(item);
  endtask

  // A request of the given mode with every field random.
  function automatic cmd_item_t random_item(input logic [1:0] mode);
    cmd_item_t item;
    item.mode = mode;
    item.rx_byte = 8'($urandom);
    item.duty_one = 16'($urandom);
    item.duty_two = 16'($urandom);
    item.duty_three = 16'($urandom);
    item.duty_four = 16'($urandom);
    return item;
  endfunction

  task automatic send_rx_byte(input logic [7:0] b);
    cmd_item_t item;
    item = random_item(MODE_RX);
    item.rx_byte = b;
    send_request(item);
  endtask

  // Streams one received frame; a random send request is slipped in before byte send_at.
  task automatic send_rx_frame(input logic [7:0] code, input logic [7:0] payload[8],
                               input bit corrupt, input int send_at);
    logic [7:0] frame[11];
    logic [7:0] sum;
    frame[0] = FRAME_HEAD;
    frame[1] = code;
    for (int i = 0; i < 8; i++) frame[2 + i] = payload[i];
    sum = 8'h00;
    for (int i = 0; i < 10; i++) sum = sum + frame[i];
    frame[10] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
    for (int i = 0; i < 11; i++) begin
      if (i == send_at) send_request(random_item(2'($urandom_range(1, 3))));
      send_rx_byte(frame[i]);
    end
  endtask

  // Lowers valid and holds the sender back until every expected result has arrived.
  task automatic wait_drained();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Extremes and special cases, with no idling on either side.
  task automatic test_directed();
    cmd_item_t item;
    logic [7:0] payload[8];
    src_idle_pct = 0;
    sink_stall_pct = 0;
    // A stray byte outside a frame is ignored.
    send_rx_byte(8'hFF);
    // Duty frame with the extreme duties.
    item = random_item(MODE_DUTY);
    item.duty_one = 16'h8000;
    item.duty_two = 16'h7FFF;
    item.duty_three = 16'hFFFF;
    item.duty_four = 16'h0000;
    send_request(item);
    send_request(random_item(MODE_TEST));
    // Good frame: unchecked function code, header value as data, a send in the middle.
    payload = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hA5, 8'hA5, 8'hFF, 8'hFF};
    send_rx_frame(8'hFF, payload, 1'b0, 5);
    // A frame with a wrong checksum is dropped.
    payload = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_rx_frame(8'h00, payload, 1'b1, -1);
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering, so the queue fills.
  task automatic test_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_cycles = 150;
    for (int i = 0; i < 10; i++) send_request(random_item(2'($urandom_range(1, 3))));
    wait_drained();
  endtask

  // Mostly well-formed frames with random content, plus sends, bad sums and noise.
  task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
    logic [7:0] payload[8];
    logic [7:0] b;
    int pick;
    int done;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        for (int i = 0; i < 8; i++) begin
          case ($urandom_range(0, 7))
            0:       payload[i] = 8'h00;
            1:       payload[i] = 8'hFF;
            2:       payload[i] = FRAME_HEAD;
            default: payload[i] = 8'($urandom);
          endcase
        end
        send_rx_frame(8'($urandom), payload, $urandom_range(0, 4) == 0, $urandom_range(0, 30));
        done += 11;
      end else if (pick < 85) begin
        send_request(random_item(2'($urandom_range(1, 3))));
        done += 1;
      end else begin
        // Line noise between frames; it never looks like a header.
        b = 8'($urandom);
        if (b == FRAME_HEAD) b = 8'h5A;
        send_rx_byte(b);
      end
    end
    wait_drained();
  endtask

  // Test sequence.
  initial begin
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    res_ch.ready = 1'b0;
    hold_cycles = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    rx_held = 4'd0;
    rx_sum = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_random_traffic(0, 0, 45);
    test_random_traffic(85, 0, 45);
    test_random_traffic(0, 85, 45);
    test_random_traffic(33, 33, 45);

    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/mlfe_pkg.sv
rtl/core/mlfe_if.sv
rtl/core/mlfe_queue.sv
rtl/core/mlfe_front.sv
rtl/core/mlfe_back.sv
rtl/core/motor_link_frame_engine_top.sv
bench/tb_motor_link_frame_engine_top.sv
